FILE: sv/ring_queue_with_tombstones_macros.svh
// ---------------------------------------------------------------------------
// ring_queue_with_tombstones_macros.svh
// Assertion macros shared by the ring queue RTL.
// ---------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_TOMBSTONES_MACROS_SVH
`define RING_QUEUE_WITH_TOMBSTONES_MACROS_SVH

// Clocked check, skipped while reset is high
`define RQT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define RQT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rqt_pkg.sv
// ---------------------------------------------------------------------------
// rqt_pkg
// Types and constants of the ring queue with tombstone removal.
// ---------------------------------------------------------------------------
package rqt_pkg;

   localparam int unsigned RING_DEPTH_DEF = 1024;
   localparam int unsigned ENTRY_W        = 32;
   localparam int unsigned SLOT_W         = 10;

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_MARK = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_FETCH = 1'b1
   } state_type;

endpackage

FILE: sv/ring_queue_with_tombstones.sv
// Enqueue, mark and empty-dequeue results pass a pending register, then the output register.
// A dequeue pops slots (tombstones plus the live entry) in one memory read loop, one read per
// popped slot, its result on the same path; else 1 item per cycle unless the output stalls.
// Synchronous reset empties the queue and drops pending results; memories keep data.
// ---------------------------------------------------------------------------
// ring_queue_with_tombstones
// Circular queue in a slot memory plus a removed-mark memory; dequeue pops
// from the head and skips marked slots, one memory read per popped slot.
// ---------------------------------------------------------------------------
`include "ring_queue_with_tombstones_macros.svh"

module ring_queue_with_tombstones
   import rqt_pkg::*;
#(
   parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [ENTRY_W-1:0] req_entry_value,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [ENTRY_W-1:0] rsp_entry_out,
   output logic [SLOT_W-1:0]  rsp_slot_out
);

   localparam int unsigned PTR_W = $clog2(RING_DEPTH);
   localparam int unsigned OCC_W = $clog2(RING_DEPTH + 1);
   localparam int unsigned SUM_W = OCC_W + 1;
   localparam int unsigned CMP_W = ((PTR_W > SLOT_W) ? PTR_W : SLOT_W) + 1;

   // Storage
   logic [ENTRY_W-1:0] slot_mem [RING_DEPTH];
   logic               mark_mem [RING_DEPTH];

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [ENTRY_W-1:0] rd_entry_ff;
   logic               rd_mark_ff;

   logic               pend_valid_ff;
   status_type         pend_status_ff;
   logic [ENTRY_W-1:0] pend_entry_ff;
   logic [SLOT_W-1:0]  pend_slot_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ENTRY_W-1:0] rsp_entry_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   op_type             op;
   logic               accept;
   logic               drain;
   logic               full;
   logic               mark_ok;
   logic [SUM_W-1:0]   tail_sum;
   logic [PTR_W-1:0]   tail_loc;
   logic [PTR_W:0]     head_nx1;
   logic [PTR_W-1:0]   head_wrap;

   logic               st_wr;
   logic               mk_wr;
   logic [PTR_W-1:0]   mk_wr_addr;
   logic               mk_wr_data;
   logic               res_valid;
   status_type         res_status;
   logic [ENTRY_W-1:0] res_entry;
   logic [SLOT_W-1:0]  res_slot;

   assign op     = op_type'(req_opcode);
   assign accept = req_valid && req_ready;
   assign drain  = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   // Address arithmetic: tail slot, head advance, mark range check
   assign full      = (occ_ff == OCC_W'(RING_DEPTH));
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(occ_ff);
   assign tail_loc  = (tail_sum >= SUM_W'(RING_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(RING_DEPTH)) : PTR_W'(tail_sum);
   assign head_nx1  = {1'b0, head_ff} + 1'b1;
   assign head_wrap = (head_nx1 == (PTR_W+1)'(RING_DEPTH)) ? '0 : PTR_W'(head_nx1);
   assign mark_ok   = (CMP_W'(req_slot_index) < CMP_W'(RING_DEPTH));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (op == OP_DEQ) && (occ_ff != '0)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (!rd_mark_ff || (occ_ff == OCC_W'(1))) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs: take a new transfer only when idle and the result slot frees up
   always_comb begin
      case (state_ff)
         S_IDLE:  req_ready = !pend_valid_ff || drain;
         S_FETCH: req_ready = 1'b0;
         default: req_ready = 1'b0;
      endcase
   end

   // Datapath: memory writes, pointer updates and result
   always_comb begin
      head_in    = head_ff;
      occ_in     = occ_ff;
      st_wr      = 1'b0;
      mk_wr      = 1'b0;
      mk_wr_addr = tail_loc;
      mk_wr_data = 1'b0;
      res_valid  = 1'b0;
      res_status = ST_OK;
      res_entry  = '0;
      res_slot   = '0;
      if ((state_ff == S_IDLE) && accept) begin
         case (op)
            OP_ENQ: begin
               res_valid = 1'b1;
               if (full) begin
                  res_status = ST_FULL;
               end else begin
                  st_wr    = 1'b1;
                  mk_wr    = 1'b1;
                  occ_in   = occ_ff + 1'b1;
                  res_slot = SLOT_W'(tail_loc);
               end
            end
            OP_DEQ: begin
               if (occ_ff == '0) begin
                  res_valid  = 1'b1;
                  res_status = ST_EMPTY;
               end
            end
            OP_MARK: begin
               res_valid  = 1'b1;
               mk_wr      = mark_ok;
               mk_wr_addr = PTR_W'(req_slot_index);
               mk_wr_data = 1'b1;
            end
            default: res_valid = 1'b1;
         endcase
      end else if (state_ff == S_FETCH) begin
         // Pop the head slot; skip it when marked
         occ_in  = occ_ff - 1'b1;
         head_in = head_wrap;
         if (!rd_mark_ff) begin
            res_valid = 1'b1;
            res_entry = rd_entry_ff;
         end else if (occ_ff == OCC_W'(1)) begin
            res_valid  = 1'b1;
            res_status = ST_EMPTY;
         end
      end
   end

   // Memories: write on enqueue/mark, read the next head slot every cycle
   always_ff @(posedge clock) begin
      if (st_wr) begin
         slot_mem[tail_loc] <= req_entry_value;
      end
      rd_entry_ff <= slot_mem[head_in];
   end

   always_ff @(posedge clock) begin
      if (mk_wr) begin
         mark_mem[mk_wr_addr] <= mk_wr_data;
      end
      rd_mark_ff <= mark_mem[head_in];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         occ_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         if (res_valid) begin
            pend_valid_ff <= 1'b1;
         end else if (drain) begin
            pend_valid_ff <= 1'b0;
         end
         if (drain) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: hold the pending result, advance it to the output
   always_ff @(posedge clock) begin
      if (res_valid) begin
         pend_status_ff <= res_status;
         pend_entry_ff  <= res_entry;
         pend_slot_ff   <= res_slot;
      end
      if (drain) begin
         rsp_status_ff <= pend_status_ff;
         rsp_entry_ff  <= pend_entry_ff;
         rsp_slot_ff   <= pend_slot_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_entry_out = rsp_entry_ff;
   assign rsp_slot_out  = rsp_slot_ff;

   // Checks
   `RQT_ASSERT(a_occ_range, clock, reset, (occ_ff <= OCC_W'(RING_DEPTH)), "occupancy above depth")
   `RQT_ASSERT(a_head_range, clock, reset, (head_ff <= PTR_W'(RING_DEPTH - 1)), "head out of ring")
   `RQT_ASSERT(a_fetch_nonempty, clock, reset, ((state_ff == S_FETCH) |-> (occ_ff != '0)), "pop from empty ring")
   `RQT_ASSERT(a_pop_dec, clock, reset, ((state_ff == S_FETCH) |=> (occ_ff == $past(occ_ff) - 1'b1)), "pop did not free a slot")
   `RQT_ASSERT(a_fetch_no_pend, clock, reset, ((state_ff == S_FETCH) |-> !pend_valid_ff), "result slot busy during pop")

endmodule
